/* src/mwsm_pkg.sv */
// shared widths and constants for the mecanum wheel speed mixer
`default_nettype none
package mwsm_pkg;
  localparam int QBITS   = 15;
  localparam int CMD_W   = 18;
  localparam int UNIT_W  = 17;
  localparam int WGT_W   = 16;
  localparam int SQR_W   = 32;
  localparam int ROOT_W  = 16;
  localparam int QUO_W   = 16;
  localparam int SPP_W   = 34;
  localparam int SPIN_W  = 19;
  localparam int MIX_W   = 20;
  localparam int MAG_W   = 19;
  localparam int WHEEL_W = 17;
  localparam int LANE_N  = 4;
  localparam logic [WGT_W-1:0] SPIN_WEIGHT_RST = 16'd26214;
  localparam logic [UNIT_W-1:0] Q_ONE = 17'd32768;
  localparam logic [SQR_W-1:0] LEN_LIMIT = 32'h4000_0000;
endpackage
`default_nettype wire

/* src/mwsm_sqrt.sv */
// pipelined integer square root, one result bit per stage
`default_nettype none
module mwsm_sqrt import mwsm_pkg::*; #(
  parameter int SW = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              i_valid,
  output logic                   i_ready,
  input  wire logic [SQR_W-1:0]  i_rad,
  input  wire logic [SW-1:0]     i_sb,
  output logic                   o_valid,
  input  wire logic              o_ready,
  output logic [ROOT_W-1:0]      o_root,
  output logic [SW-1:0]          o_sb
);
  localparam int N = ROOT_W;
  localparam int RW = ROOT_W + 2;

  logic              v_r    [N];
  logic [RW-1:0]     rem_r  [N];
  logic [ROOT_W-1:0] root_r [N];
  logic [SQR_W-1:0]  rad_r  [N];
  logic [SW-1:0]     sb_r   [N];
  logic [N:0]        adv;

  assign adv[N]  = o_ready;
  assign i_ready = adv[0];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic              pv;
    logic [RW-1:0]     prem;
    logic [ROOT_W-1:0] proot;
    logic [SQR_W-1:0]  prad;
    logic [SW-1:0]     psb;
    logic [RW+1:0]     t;
    logic [RW+1:0]     trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign pv = i_valid;
      assign prem = '0;
      assign proot = '0;
      assign prad = i_rad;
      assign psb = i_sb;
    end else begin : g_next
      assign pv = v_r[k-1];
      assign prem = rem_r[k-1];
      assign proot = root_r[k-1];
      assign prad = rad_r[k-1];
      assign psb = sb_r[k-1];
    end

    // one digit of the restoring root
    assign t     = {prem, prad[SQR_W-1 -: 2]};
    assign trial = {2'b00, proot, 2'b01};
    assign ge    = t >= trial;
    assign adv[k] = !v_r[k] || adv[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv[k]) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        rem_r[k]  <= ge ? RW'(t - trial) : RW'(t);
        root_r[k] <= {proot[ROOT_W-2:0], ge};
        rad_r[k]  <= {prad[SQR_W-3:0], 2'b00};
        sb_r[k]   <= psb;
      end
    end
  end

  assign o_valid = v_r[N-1];
  assign o_root  = root_r[N-1];
  assign o_sb    = sb_r[N-1];
endmodule
`default_nettype wire

/* src/mwsm_div.sv */
// pipelined restoring divider, several lanes over one shared divisor
`default_nettype none
module mwsm_div import mwsm_pkg::*; #(
  parameter int NW    = 31,
  parameter int DW    = 17,
  parameter int QW    = QUO_W,
  parameter int SW    = 4,
  parameter int LANES = 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       i_valid,
  output logic                            i_ready,
  input  wire logic [LANES-1:0][NW-1:0]   i_num,
  input  wire logic [DW-1:0]              i_den,
  input  wire logic [SW-1:0]              i_sb,
  output logic                            o_valid,
  input  wire logic                       o_ready,
  output logic [LANES-1:0][QW-1:0]        o_quo,
  output logic [SW-1:0]                   o_sb
);
  logic                       v_r   [QW];
  logic [DW-1:0]              den_r [QW];
  logic [SW-1:0]              sb_r  [QW];
  logic [LANES-1:0][DW-1:0]   rem_r [QW];
  logic [LANES-1:0][QW-1:0]   nq_r  [QW];
  logic [QW:0]                adv;

  assign adv[QW] = o_ready;
  assign i_ready = adv[0];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                     pv;
    logic [DW-1:0]            pden;
    logic [SW-1:0]            psb;
    logic [LANES-1:0][DW-1:0] prem;
    logic [LANES-1:0][QW-1:0] pnq;
    logic [LANES-1:0][DW-1:0] rem_nxt;
    logic [LANES-1:0][QW-1:0] nq_nxt;

    if (k == 0) begin : g_first
      assign pv = i_valid;
      assign pden = i_den;
      assign psb = i_sb;
      for (genvar l = 0; l < LANES; l++) begin : g_ld
        assign prem[l] = DW'(i_num[l][NW-1:QW]);
        assign pnq[l]  = i_num[l][QW-1:0];
      end
    end else begin : g_next
      assign pv = v_r[k-1];
      assign pden = den_r[k-1];
      assign psb = sb_r[k-1];
      assign prem = rem_r[k-1];
      assign pnq = nq_r[k-1];
    end

    // one quotient bit per lane
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DW:0] t;
      logic        ge;
      assign t  = {prem[l], pnq[l][QW-1]};
      assign ge = t >= {1'b0, pden};
      assign rem_nxt[l] = ge ? DW'(t - {1'b0, pden}) : DW'(t);
      assign nq_nxt[l]  = {pnq[l][QW-2:0], ge};
    end

    assign adv[k] = !v_r[k] || adv[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv[k]) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        den_r[k] <= pden;
        sb_r[k]  <= psb;
        rem_r[k] <= rem_nxt;
        nq_r[k]  <= nq_nxt;
      end
    end
  end

  assign o_valid = v_r[QW-1];
  assign o_quo   = nq_r[QW-1];
  assign o_sb    = sb_r[QW-1];
endmodule
`default_nettype wire

/* src/mecanum_wheel_speed_mixer.sv */
// top level: clamp, vector length, unit scaling, wheel mix and normalization
// registered stages, input to result: 1 input, 16 root, 2 x 16 divide, 3 mix, 1 output
// throughput: one command per cycle while out_tready stays high, set by the fully pipelined root and divider stages
// each stage moves on when the next one is empty or moving, so bubbles close up
// reset clears all stage valid bits and loads spin_weight with 0.8 (26214)
`default_nettype none
module mecanum_wheel_speed_mixer import mwsm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // cmd_x [17:0], cmd_y [35:18], cmd_spin [53:36], zero [55:54]
  input  wire logic [55:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // wheel_left_front [16:0], wheel_left_back [33:17],
  // wheel_right_back [50:34], wheel_right_front [67:51], zero [71:68]
  output logic [71:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);
  localparam int SQ_SB  = 2 + SPP_W + 2 + 2 * UNIT_W;
  localparam int D1_SB  = 1 + SPP_W + 2;
  localparam int D1_NW  = 2 * QBITS + 1;
  localparam int D2_NW  = MAG_W + QBITS;

  // configuration register
  logic [WGT_W-1:0] spin_weight_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spin_weight_r <= SPIN_WEIGHT_RST;
    end else if (cfg_valid) begin
      spin_weight_r <= cfg_data;
    end
  end

  // input stage: clamp, squares and spin product
  logic signed [CMD_W-1:0] cx, cy, cs, lx, ly;
  logic [UNIT_W-1:0]       ax, ay;
  logic [CMD_W-1:0]        as;
  logic                    a_v_r, a_sx_r, a_sy_r, a_ss_r;
  logic [UNIT_W-1:0]       a_ax_r, a_ay_r;
  logic [SQR_W-1:0]        a_q_r;
  logic [SPP_W-1:0]        a_sp_r;
  logic                    adv_a;
  logic                    sq_i_ready;

  assign cx = in_tdata[17:0];
  assign cy = in_tdata[35:18];
  assign cs = in_tdata[53:36];
  assign lx = (cx > 18'sd32768) ? 18'sd32768 : (cx < -18'sd32768) ? -18'sd32768 : cx;
  assign ly = (cy > 18'sd32768) ? 18'sd32768 : (cy < -18'sd32768) ? -18'sd32768 : cy;
  assign ax = lx[CMD_W-1] ? UNIT_W'(-lx) : UNIT_W'(lx);
  assign ay = ly[CMD_W-1] ? UNIT_W'(-ly) : UNIT_W'(ly);
  assign as = cs[CMD_W-1] ? CMD_W'(-cs) : CMD_W'(cs);
  assign adv_a = !a_v_r || sq_i_ready;
  assign in_tready = adv_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv_a) begin
      a_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_sx_r <= lx[CMD_W-1];
      a_sy_r <= ly[CMD_W-1];
      a_ss_r <= cs[CMD_W-1];
      a_ax_r <= ax;
      a_ay_r <= ay;
      a_q_r  <= SQR_W'(ax) * SQR_W'(ax) + SQR_W'(ay) * SQR_W'(ay);
      a_sp_r <= SPP_W'(as) * SPP_W'(spin_weight_r);
    end
  end

  // vector length
  logic              sq_o_valid, d1_i_ready;
  logic [ROOT_W-1:0] sq_root;
  logic [SQ_SB-1:0]  sq_o_sb;

  mwsm_sqrt #(.SW(SQ_SB)) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (a_v_r),
    .i_ready (sq_i_ready),
    .i_rad   (a_q_r),
    .i_sb    ({a_q_r > LEN_LIMIT, a_ss_r, a_sp_r, a_sx_r, a_sy_r, a_ax_r, a_ay_r}),
    .o_valid (sq_o_valid),
    .o_ready (d1_i_ready),
    .o_root  (sq_root),
    .o_sb    (sq_o_sb)
  );

  // unit scaling, divisor 1.0 when the vector is short
  logic                  sq_big, sq_ss, sq_sx, sq_sy;
  logic [SPP_W-1:0]      sq_sp;
  logic [UNIT_W-1:0]     sq_ax, sq_ay, len;
  logic [1:0][D1_NW-1:0] d1_num;
  logic                  d1_o_valid, adv_m;
  logic [1:0][QUO_W-1:0] d1_quo;
  logic [D1_SB-1:0]      d1_o_sb;

  assign {sq_big, sq_ss, sq_sp, sq_sx, sq_sy, sq_ax, sq_ay} = sq_o_sb;
  assign len = sq_big ? {1'b0, sq_root} : Q_ONE;
  assign d1_num[0] = D1_NW'({sq_ax, 15'd0} + 32'(len >> 1));
  assign d1_num[1] = D1_NW'({sq_ay, 15'd0} + 32'(len >> 1));

  mwsm_div #(.NW(D1_NW), .DW(UNIT_W), .QW(QUO_W), .SW(D1_SB), .LANES(2)) u_div_len (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (sq_o_valid),
    .i_ready (d1_i_ready),
    .i_num   (d1_num),
    .i_den   (len),
    .i_sb    ({sq_ss, sq_sp, sq_sx, sq_sy}),
    .o_valid (d1_o_valid),
    .o_ready (adv_m),
    .o_quo   (d1_quo),
    .o_sb    (d1_o_sb)
  );

  // wheel mixes
  logic                     d1_ss, d1_sx, d1_sy;
  logic [SPP_W-1:0]         d1_sp;
  logic [SPIN_W-1:0]        smag;
  logic signed [MIX_W-1:0]  vx, vy, vs;
  logic                     m_v_r, adv_g;
  logic signed [MIX_W-1:0]  m_mix_r [LANE_N];

  assign {d1_ss, d1_sp, d1_sx, d1_sy} = d1_o_sb;
  assign smag = SPIN_W'((d1_sp + SPP_W'(16384)) >> QBITS);
  assign vx = d1_sx ? -MIX_W'(d1_quo[0]) : MIX_W'(d1_quo[0]);
  assign vy = d1_sy ? -MIX_W'(d1_quo[1]) : MIX_W'(d1_quo[1]);
  assign vs = d1_ss ? -MIX_W'(smag) : MIX_W'(smag);
  assign adv_m = !m_v_r || adv_g;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (adv_m) begin
      m_v_r <= d1_o_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_m) begin
      m_mix_r[0] <= vx - vy - vs;
      m_mix_r[1] <= vx + vy - vs;
      m_mix_r[2] <= vx - vy + vs;
      m_mix_r[3] <= vx + vy + vs;
    end
  end

  // magnitudes
  logic             g_v_r, adv_c;
  logic [MAG_W-1:0] g_mag_r [LANE_N];
  logic [LANE_N-1:0] g_neg_r;
  assign adv_g = !g_v_r || adv_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else if (adv_g) begin
      g_v_r <= m_v_r;
    end
  end

  for (genvar i = 0; i < LANE_N; i++) begin : g_mag
    always_ff @(posedge clk) begin
      if (adv_g) begin
        g_mag_r[i] <= m_mix_r[i][MIX_W-1] ? MAG_W'(-m_mix_r[i]) : MAG_W'(m_mix_r[i]);
        g_neg_r[i] <= m_mix_r[i][MIX_W-1];
      end
    end
  end

  // largest magnitude, at least 1.0
  logic [MAG_W-1:0]  mx01, mx23, mxa;
  logic              c_v_r, d2_i_ready;
  logic [MAG_W-1:0]  c_mag_r [LANE_N];
  logic [LANE_N-1:0] c_neg_r;
  logic [MAG_W-1:0]  c_max_r;

  assign mx01 = (g_mag_r[0] > g_mag_r[1]) ? g_mag_r[0] : g_mag_r[1];
  assign mx23 = (g_mag_r[2] > g_mag_r[3]) ? g_mag_r[2] : g_mag_r[3];
  assign mxa  = (mx01 > mx23) ? mx01 : mx23;
  assign adv_c = !c_v_r || d2_i_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (adv_c) begin
      c_v_r <= g_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_c) begin
      c_mag_r <= g_mag_r;
      c_neg_r <= g_neg_r;
      c_max_r <= (mxa > MAG_W'(Q_ONE)) ? mxa : MAG_W'(Q_ONE);
    end
  end

  // normalization
  logic [LANE_N-1:0][D2_NW-1:0] d2_num;
  logic                         d2_o_valid, adv_o;
  logic [LANE_N-1:0][QUO_W-1:0] d2_quo;
  logic [LANE_N-1:0]            d2_neg;

  for (genvar i = 0; i < LANE_N; i++) begin : g_num
    assign d2_num[i] = {c_mag_r[i], 15'd0} + D2_NW'(c_max_r >> 1);
  end

  mwsm_div #(.NW(D2_NW), .DW(MAG_W), .QW(QUO_W), .SW(LANE_N), .LANES(LANE_N)) u_div_norm (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (c_v_r),
    .i_ready (d2_i_ready),
    .i_num   (d2_num),
    .i_den   (c_max_r),
    .i_sb    (c_neg_r),
    .o_valid (d2_o_valid),
    .o_ready (adv_o),
    .o_quo   (d2_quo),
    .o_sb    (d2_neg)
  );

  // output register
  logic                      o_v_r;
  logic signed [WHEEL_W-1:0] o_whl_r [LANE_N];
  assign adv_o = !o_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (adv_o) begin
      o_v_r <= d2_o_valid;
    end
  end

  for (genvar i = 0; i < LANE_N; i++) begin : g_out
    always_ff @(posedge clk) begin
      if (adv_o) begin
        o_whl_r[i] <= d2_neg[i] ? -WHEEL_W'(d2_quo[i]) : WHEEL_W'(d2_quo[i]);
      end
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = {4'd0, o_whl_r[3], o_whl_r[2], o_whl_r[1], o_whl_r[0]};

  // checks
  a_norm_floor: assert property (@(posedge clk) disable iff (!rst_n)
    c_v_r |-> c_max_r >= MAG_W'(Q_ONE)) else $error("normalizer below 1.0");

  a_norm_max: assert property (@(posedge clk) disable iff (!rst_n)
    c_v_r |-> (c_mag_r[0] <= c_max_r && c_mag_r[1] <= c_max_r &&
               c_mag_r[2] <= c_max_r && c_mag_r[3] <= c_max_r))
    else $error("mix magnitude above normalizer");

  a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (o_whl_r[0] >= -17'sd32768 && o_whl_r[1] >= -17'sd32768 &&
                    o_whl_r[2] >= -17'sd32768 && o_whl_r[3] >= -17'sd32768))
    else $error("wheel speed out of range");
endmodule
`default_nettype wire

/* test/tb_mecanum_wheel_speed_mixer.sv */
// testbench for the mecanum wheel speed mixer: directed table, random commands, predictor check
`default_nettype none
module tb_mecanum_wheel_speed_mixer;
  import mwsm_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // cmd_x [17:0], cmd_y [35:18], cmd_spin [53:36], zero [55:54]
  logic [55:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // wheel_left_front [16:0], wheel_left_back [33:17],
  // wheel_right_back [50:34], wheel_right_front [67:51], zero [71:68]
  logic [71:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  typedef struct packed {
    logic [WHEEL_W-1:0] rf;
    logic [WHEEL_W-1:0] rb;
    logic [WHEEL_W-1:0] lb;
    logic [WHEEL_W-1:0] lf;
  } wheels_t;

  typedef struct {
    logic [CMD_W-1:0] x;
    logic [CMD_W-1:0] y;
    logic [CMD_W-1:0] s;
    bit               known;
    wheels_t          w;
  } cmd_row_t;

  localparam logic [WHEEL_W-1:0] W_POS1 = 17'd32768;
  localparam logic [WHEEL_W-1:0] W_NEG1 = 17'h18000;

  wheels_t       wheel_queue[$];
  logic [15:0]   gain_model;
  int            err_count;
  int            send_idle_pct;
  int            recv_stall_pct;
  cmd_row_t      dir_rows[$];

  mecanum_wheel_speed_mixer u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sign * round(|v| * mul / div), ties away from zero
  function automatic longint round_scale(longint v, longint mul, longint div);
    longint mag;
    longint q;
    mag = (v < 0) ? -v : v;
    q = (mag * mul + div / 2) / div;
    return (v < 0) ? -q : q;
  endfunction

  function automatic longint int_root(longint n);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= n) r = r + 1;
    return r;
  endfunction

  function automatic wheels_t mix_wheels(logic [CMD_W-1:0] cx, logic [CMD_W-1:0] cy,
                                         logic [CMD_W-1:0] cs, logic [15:0] gain);
    longint x, y, sp, s, q, len, mx, a;
    longint m[4];
    wheels_t w;
    x = longint'($signed(cx));
    y = longint'($signed(cy));
    sp = longint'($signed(cs));
    if (x > 32768) x = 32768;
    if (x < -32768) x = -32768;
    if (y > 32768) y = 32768;
    if (y < -32768) y = -32768;
    q = x * x + y * y;
    if (q > 64'sd1073741824) begin
      len = int_root(q);
      x = round_scale(x, 32768, len);
      y = round_scale(y, 32768, len);
    end
    s = round_scale(sp, longint'(gain), 32768);
    m[0] = x - y - s;
    m[1] = x + y - s;
    m[2] = x - y + s;
    m[3] = x + y + s;
    mx = 32768;
    for (int i = 0; i < 4; i++) begin
      a = (m[i] < 0) ? -m[i] : m[i];
      if (a > mx) mx = a;
    end
    w.lf = WHEEL_W'(round_scale(m[0], 32768, mx));
    w.lb = WHEEL_W'(round_scale(m[1], 32768, mx));
    w.rb = WHEEL_W'(round_scale(m[2], 32768, mx));
    w.rf = WHEEL_W'(round_scale(m[3], 32768, mx));
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [WHEEL_W-1:0] got,
                                 logic [WHEEL_W-1:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what,
             $signed(got), $signed(want), $realtime);
    err_count++;
  endtask

  // result side: random stall, compare against oldest expectation
  initial begin
    wheels_t got;
    wheels_t want;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = out_tdata[67:0];
        if (wheel_queue.size() == 0) begin
          $display("unexpected result transaction at %0t", $realtime);
          err_count++;
        end else begin
          want = wheel_queue.pop_front();
          if (got.lf !== want.lf) report_mismatch("left_front", got.lf, want.lf);
          if (got.lb !== want.lb) report_mismatch("left_back", got.lb, want.lb);
          if (got.rb !== want.rb) report_mismatch("right_back", got.rb, want.rb);
          if (got.rf !== want.rf) report_mismatch("right_front", got.rf, want.rf);
          if (out_tdata[71:68] !== 4'd0) begin
            $display("padding bits set at %0t", $realtime);
            err_count++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_cmd(logic [CMD_W-1:0] cx, logic [CMD_W-1:0] cy,
                          logic [CMD_W-1:0] cs, bit known, wheels_t kw);
    wheels_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, cs, cy, cx};
    p = mix_wheels(cx, cy, cs, gain_model);
    if (known && p !== kw) begin
      $display("table row disagrees with predictor at %0t", $realtime);
      err_count++;
    end
    wheel_queue.push_back(known ? kw : p);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_and_settle();
    in_tvalid <= 1'b0;
    while (wheel_queue.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_gain(logic [15:0] g);
    cfg_valid <= 1'b1;
    cfg_data <= g;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    gain_model = g;
  endtask

  function automatic logic [CMD_W-1:0] rand_field();
    int k;
    k = $urandom_range(9);
    if (k == 0) return CMD_W'($urandom);
    if (k == 1) return CMD_W'($urandom_range(65536));
    if (k == 2) return CMD_W'(-$urandom_range(65536));
    if (k < 6) return CMD_W'($urandom_range(32768));
    return CMD_W'(-$urandom_range(32768));
  endfunction

  function automatic cmd_row_t row(int x, int y, int s, bit known, wheels_t w);
    cmd_row_t r;
    r.x = CMD_W'(x);
    r.y = CMD_W'(y);
    r.s = CMD_W'(s);
    r.known = known;
    r.w = w;
    return r;
  endfunction

  initial begin
    wheels_t zero_w;
    wheels_t fwd_w;
    wheels_t back_w;
    logic [15:0] gains[6];
    zero_w = '0;
    fwd_w = {W_POS1, W_POS1, W_POS1, W_POS1};
    back_w = {W_NEG1, W_NEG1, W_NEG1, W_NEG1};
    gains = '{16'd0, 16'hFFFF, 16'd32768, 16'd1, 16'd26214, 16'd13107};
    err_count = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    gain_model = SPIN_WEIGHT_RST;

    // directed table: extremes, clamping, length scaling in every quadrant, spin out of range
    dir_rows.push_back(row(0, 0, 0, 1, zero_w));
    dir_rows.push_back(row(32768, 0, 0, 1, fwd_w));
    dir_rows.push_back(row(-32768, 0, 0, 1, back_w));
    dir_rows.push_back(row(65536, 0, 0, 1, fwd_w));
    dir_rows.push_back(row(-65536, 0, 0, 1, back_w));
    dir_rows.push_back(row(0, 65536, 0, 0, zero_w));
    dir_rows.push_back(row(0, -65536, 0, 0, zero_w));
    dir_rows.push_back(row(32768, 32768, 0, 0, zero_w));
    dir_rows.push_back(row(-32768, 32768, 0, 0, zero_w));
    dir_rows.push_back(row(-32768, -32768, 0, 0, zero_w));
    dir_rows.push_back(row(32768, -32768, 0, 0, zero_w));
    dir_rows.push_back(row(-30000, 20000, 1000, 0, zero_w));
    dir_rows.push_back(row(20000, 20000, 0, 0, zero_w));
    dir_rows.push_back(row(23170, 23170, 0, 0, zero_w));
    dir_rows.push_back(row(23171, 23171, 0, 0, zero_w));
    dir_rows.push_back(row(0, 0, 65536, 0, zero_w));
    dir_rows.push_back(row(0, 0, -65536, 0, zero_w));
    dir_rows.push_back(row(0, 0, 131071, 0, zero_w));
    dir_rows.push_back(row(0, 0, -131072, 0, zero_w));
    dir_rows.push_back(row(131071, -131072, 131071, 0, zero_w));
    dir_rows.push_back(row(-1, 1, -1, 0, zero_w));
    dir_rows.push_back(row(12345, -6789, 4000, 0, zero_w));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset gain first, then the largest spin weight
    foreach (dir_rows[i])
      send_cmd(dir_rows[i].x, dir_rows[i].y, dir_rows[i].s, dir_rows[i].known, dir_rows[i].w);
    drain_and_settle();
    write_gain(16'hFFFF);
    foreach (dir_rows[i])
      send_cmd(dir_rows[i].x, dir_rows[i].y, dir_rows[i].s, 0, zero_w);
    drain_and_settle();

    // random phases, each with its own gain and idling mix
    for (int ph = 0; ph < 12; ph++) begin
      write_gain(gains[ph % 6]);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 70; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 70; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      for (int n = 0; n < 54; n++)
        send_cmd(rand_field(), rand_field(), rand_field(), 0, zero_w);
      drain_and_settle();
    end

    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire
